[hw/rtl/lru_ttl_byte_budget_cache_unit_macros.svh]
// Assertion macros for the cache directory checker.
`ifndef LRU_TTL_BYTE_BUDGET_CACHE_UNIT_MACROS_SVH
`define LRU_TTL_BYTE_BUDGET_CACHE_UNIT_MACROS_SVH

// same-cycle implication
`define LTBC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LTBC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ltbc_pkg.sv]
// Types and constants of the cache directory.
package ltbc_pkg;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INVAL  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OUT_HIT       = 3'd0,
        OUT_INSERTED  = 3'd1,
        OUT_TOO_LARGE = 3'd2,
        OUT_REMOVED   = 3'd3,
        OUT_ABSENT    = 3'd4,
        OUT_CLEARED   = 3'd5
    } outcome_t;

    localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;
    localparam logic [1:0] REG_MAX_BYTES   = 2'd1;
    localparam logic [1:0] REG_TTL_TICKS   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_DECIDE,
        S_BUDGET,
        S_LIMIT,
        S_OLDEST,
        S_EVICT,
        S_FREE,
        S_INSERT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] tag;
        logic [31:0] last;
        logic [31:0] size;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic        found;
        logic [31:0] tag;
        logic [31:0] last;
        logic [31:0] size;
        logic        best_vld;
        logic [31:0] best_size;
    } scan_res_t;

endpackage

[hw/rtl/ltbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ltbc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/ltbc_scan.sv]
// Shared per-slot compare unit: key match and oldest-entry search.
module ltbc_scan
    import ltbc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       clear,
    input  logic                                       step,
    input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] slot,
    input  logic                                       slot_valid,
    input  row_t                                       row,
    input  logic [31:0]                                key,
    input  logic [31:0]                                now,
    output scan_res_t                                  res,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] found_slot,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] best_slot
);

    localparam int IW = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

    logic          found_reg, found_next;
    logic          best_vld_reg, best_vld_next;
    logic [IW-1:0] found_slot_reg;
    logic [IW-1:0] best_slot_reg;
    logic [31:0]   tag_reg, last_reg, size_reg;
    logic [31:0]   best_age_reg, best_size_reg;
    logic [31:0]   age;
    logic          match, older;

    assign age   = now - row.last;
    assign match = step && slot_valid && (row.key == key) && !found_reg;
    assign older = step && slot_valid && (!best_vld_reg || age > best_age_reg);

    always_comb
    begin
        found_next    = found_reg;
        best_vld_next = best_vld_reg;
        if (clear)
        begin
            found_next    = 1'b0;
            best_vld_next = 1'b0;
        end
        else
        begin
            if (match)
            begin
                found_next = 1'b1;
            end
            if (older)
            begin
                best_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            best_vld_reg <= 1'b0;
        end
        else
        begin
            found_reg    <= found_next;
            best_vld_reg <= best_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clear && match)
        begin
            found_slot_reg <= slot;
            tag_reg        <= row.tag;
            last_reg       <= row.last;
            size_reg       <= row.size;
        end
        if (!clear && older)
        begin
            best_slot_reg <= slot;
            best_age_reg  <= age;
            best_size_reg <= row.size;
        end
    end

    assign res.found     = found_reg;
    assign res.tag       = tag_reg;
    assign res.last      = last_reg;
    assign res.size      = size_reg;
    assign res.best_vld  = best_vld_reg;
    assign res.best_size = best_size_reg;
    assign found_slot    = found_slot_reg;
    assign best_slot     = best_slot_reg;

endmodule

[hw/rtl/lru_ttl_byte_budget_cache_unit.sv]
// LRU cache directory with TTL expiry and byte budget: top level.
// A request is taken when start is high and busy is low; busy stays high until the
// result, which shows for one cycle with done and cannot be held off. Clear and the
// unused command go straight to the finish state. Lookup and invalidate walk every
// slot through the entry RAM's single read port; a miss insert adds the budget and
// limit checks, one walk of all slots per eviction, and the free-slot search and write.
module lru_ttl_byte_budget_cache_unit
    import ltbc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] key,
    input  logic [31:0] path_tag,
    input  logic [31:0] model_bytes,
    input  logic [31:0] now_ticks,
    output logic        done,
    output logic [2:0]  outcome,
    output logic [4:0]  evicted_now,
    output logic [4:0]  entries_in_use,
    output logic [31:0] bytes_in_use,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total,
    output logic [31:0] eviction_total
);

    localparam int IW   = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
    localparam int CNTW = $clog2(ENTRIES + 1) > 0 ? $clog2(ENTRIES + 1) : 1;
    localparam logic [IW:0] IDX_END = (IW + 1)'(ENTRIES);

    state_t state_reg, state_next;

    cmd_t          cmd_reg;
    logic [31:0]   key_reg, tag_reg, size_reg, now_reg;
    logic [4:0]    max_entries_reg;
    logic [31:0]   max_bytes_reg, ttl_reg;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]   total_reg, total_next;
    logic [31:0]   hits_reg, hits_next;
    logic [31:0]   misses_reg, misses_next;
    logic [31:0]   evs_reg, evs_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [CNTW-1:0] evicted_reg, evicted_next;
    logic          extra_reg, extra_next;
    outcome_t      outcome_reg, outcome_next;
    logic          done_reg, done_next;
    logic [IW:0]   idx_reg, idx_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    row_t          ram_wrow;
    logic [ROW_W-1:0] ram_rdata;
    row_t          ram_rrow;

    logic          scan_clear;
    logic          in_scan, scan_done;
    scan_res_t     res;
    logic [IW-1:0] found_slot, best_slot;

    logic          accept, hit, over, at_limit;
    logic [31:0]   limit;

    assign accept   = start && (state_reg == S_IDLE);
    assign in_scan  = (state_reg == S_FIND) || (state_reg == S_OLDEST);
    assign scan_done = (idx_reg == IDX_END) && !chk_vld_reg;
    assign ram_rrow = row_t'(ram_rdata);
    assign hit      = res.found && ((now_reg - res.last) <= ttl_reg) && (res.tag == tag_reg);
    assign over     = ({1'b0, total_reg} + {1'b0, size_reg}) > {1'b0, max_bytes_reg};
    assign limit    = (32'(max_entries_reg) > 32'(ENTRIES)) ? 32'(ENTRIES)
                                                           : 32'(max_entries_reg);
    assign at_limit = 32'(count_reg) >= limit;

    ltbc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ROW_W'(ram_wrow)),
        .raddr (idx_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    ltbc_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (scan_clear),
        .step       (chk_vld_reg),
        .slot       (chk_idx_reg),
        .slot_valid (valid_reg[chk_idx_reg]),
        .row        (ram_rrow),
        .key        (key_reg),
        .now        (now_reg),
        .res        (res),
        .found_slot (found_slot),
        .best_slot  (best_slot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd_t'(command) == CMD_LOOKUP || cmd_t'(command) == CMD_INVAL)
                    begin
                        state_next = S_FIND;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FIND:
            begin
                if (scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (cmd_reg != CMD_LOOKUP || hit || size_reg > max_bytes_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_BUDGET;
                end
            end
            S_BUDGET:
            begin
                state_next = (count_reg != '0 && over) ? S_OLDEST : S_LIMIT;
            end
            S_LIMIT:
            begin
                state_next = (count_reg != '0 && at_limit) ? S_OLDEST : S_FREE;
            end
            S_OLDEST:
            begin
                if (scan_done)
                begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT:
            begin
                state_next = extra_reg ? S_FREE : S_BUDGET;
            end
            S_FREE:
            begin
                if (!valid_reg[idx_reg[IW-1:0]])
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next   = valid_reg;
        total_next   = total_reg;
        hits_next    = hits_reg;
        misses_next  = misses_reg;
        evs_next     = evs_reg;
        count_next   = count_reg;
        evicted_next = evicted_reg;
        extra_next   = extra_reg;
        outcome_next = outcome_reg;
        idx_next     = idx_reg;
        chk_vld_next = 1'b0;
        chk_idx_next = chk_idx_reg;
        scan_clear   = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = found_slot;
        ram_wrow     = '{key: key_reg, tag: tag_reg, last: now_reg, size: res.size};
        done_next    = (state_reg == S_FINISH);

        if (in_scan && idx_reg != IDX_END)
        begin
            idx_next     = idx_reg + 1'b1;
            chk_vld_next = 1'b1;
            chk_idx_next = idx_reg[IW-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    evicted_next = '0;
                    extra_next   = 1'b0;
                    idx_next     = '0;
                    scan_clear   = 1'b1;
                    if (cmd_t'(command) == CMD_CLEAR)
                    begin
                        valid_next   = '0;
                        total_next   = '0;
                        count_next   = '0;
                        outcome_next = OUT_CLEARED;
                    end
                    else
                    begin
                        outcome_next = OUT_ABSENT;
                    end
                end
            end
            S_DECIDE:
            begin
                if (cmd_reg == CMD_LOOKUP && hit)
                begin
                    hits_next    = (hits_reg == '1) ? hits_reg : hits_reg + 1'b1;
                    outcome_next = OUT_HIT;
                    ram_we       = 1'b1;
                end
                else
                begin
                    if (res.found)
                    begin
                        valid_next[found_slot] = 1'b0;
                        total_next = total_reg - res.size;
                        count_next = count_reg - 1'b1;
                    end
                    if (cmd_reg == CMD_INVAL)
                    begin
                        outcome_next = res.found ? OUT_REMOVED : OUT_ABSENT;
                    end
                    else
                    begin
                        misses_next  = (misses_reg == '1) ? misses_reg : misses_reg + 1'b1;
                        outcome_next = (size_reg > max_bytes_reg) ? OUT_TOO_LARGE
                                                                  : OUT_INSERTED;
                    end
                end
            end
            S_BUDGET:
            begin
                idx_next   = '0;
                scan_clear = 1'b1;
            end
            S_LIMIT:
            begin
                idx_next   = '0;
                scan_clear = 1'b1;
                extra_next = 1'b1;
            end
            S_EVICT:
            begin
                valid_next[best_slot] = 1'b0;
                total_next   = total_reg - res.best_size;
                count_next   = count_reg - 1'b1;
                evicted_next = evicted_reg + 1'b1;
                evs_next     = (evs_reg == '1) ? evs_reg : evs_reg + 1'b1;
                idx_next     = '0;
            end
            S_FREE:
            begin
                if (valid_reg[idx_reg[IW-1:0]])
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_INSERT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[IW-1:0];
                ram_wrow  = '{key: key_reg, tag: tag_reg, last: now_reg, size: size_reg};
                valid_next[idx_reg[IW-1:0]] = 1'b1;
                total_next = total_reg + size_reg;
                count_next = count_reg + 1'b1;
            end
            S_FIND, S_OLDEST, S_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            total_reg       <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            evs_reg         <= '0;
            count_reg       <= '0;
            evicted_reg     <= '0;
            extra_reg       <= 1'b0;
            outcome_reg     <= OUT_ABSENT;
            done_reg        <= 1'b0;
            idx_reg         <= '0;
            chk_vld_reg     <= 1'b0;
            max_entries_reg <= 5'd16;
            max_bytes_reg   <= 32'd268435456;
            ttl_reg         <= 32'd3600;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            total_reg   <= total_next;
            hits_reg    <= hits_next;
            misses_reg  <= misses_next;
            evs_reg     <= evs_next;
            count_reg   <= count_next;
            evicted_reg <= evicted_next;
            extra_reg   <= extra_next;
            outcome_reg <= outcome_next;
            done_reg    <= done_next;
            idx_reg     <= idx_next;
            chk_vld_reg <= chk_vld_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_MAX_ENTRIES: max_entries_reg <= cfg_data[4:0];
                    REG_MAX_BYTES:   max_bytes_reg   <= cfg_data;
                    REG_TTL_TICKS:   ttl_reg         <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        if (accept)
        begin
            cmd_reg  <= cmd_t'(command);
            key_reg  <= key;
            tag_reg  <= path_tag;
            size_reg <= model_bytes;
            now_reg  <= now_ticks;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign outcome        = outcome_reg;
    assign evicted_now    = (32'(evicted_reg) > 32'd31) ? 5'd31 : 5'(evicted_reg);
    assign entries_in_use = (32'(count_reg) > 32'd31) ? 5'd31 : 5'(count_reg);
    assign bytes_in_use   = total_reg;
    assign hit_total      = hits_reg;
    assign miss_total     = misses_reg;
    assign eviction_total = evs_reg;

endmodule

[hw/rtl/ltbc_checker.sv]
// Port-level checker for the cache directory, bound to the top level.
`include "lru_ttl_byte_budget_cache_unit_macros.svh"

module ltbc_port_props (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    `LTBC_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request not taken")
    `LTBC_ASSERT_NOW(a_done_idle, done, !busy, "result while still busy")
    `LTBC_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
    `LTBC_ASSERT_NEXT(a_done_after_busy, !busy && !done, !done, "result without request")

endmodule

bind lru_ttl_byte_budget_cache_unit ltbc_port_props u_ltbc_port_props (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
